// ----- hdl/ppgfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPG front end package
// Register indexes, register widths and reset values shared by the front end
// and its checker.
// ----------------------------------------------------------------------------
package ppgfe_pkg;

    localparam int REG_W     = 18;   // widest configuration register
    localparam int DRV_W     = 8;    // LED drive and drive limit registers
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FINGER_THRESHOLD = 3'd0,
        CFG_DC_LOW           = 3'd1,
        CFG_DC_HIGH          = 3'd2,
        CFG_DRIVE_STEP       = 3'd3,
        CFG_DRIVE_MIN        = 3'd4,
        CFG_DRIVE_MAX        = 3'd5,
        CFG_DRIVE_INITIAL    = 3'd6
    } cfg_index_t;

    localparam logic [REG_W-1:0] FINGER_THRESHOLD_RST = 18'd10000;
    localparam logic [REG_W-1:0] DC_LOW_RST           = 18'd20000;
    localparam logic [REG_W-1:0] DC_HIGH_RST          = 18'd50000;
    localparam logic [DRV_W-1:0] DRIVE_STEP_RST       = 8'd5;
    localparam logic [DRV_W-1:0] DRIVE_MIN_RST        = 8'd10;
    localparam logic [DRV_W-1:0] DRIVE_MAX_RST        = 8'd255;
    localparam logic [DRV_W-1:0] DRIVE_INITIAL_RST    = 8'd60;

endpackage
`default_nettype wire

// ----- hdl/ppg_led_agc_fir_front_end.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPG LED gain control and FIR smoothing front end
// Finger detection, windowed LED drive control and 1-2-4-2-1 smoothing of the
// infrared and red photodiode samples.
// ----------------------------------------------------------------------------
// The block takes one infrared/red sample pair per clock cycle while the
// output is not stalled, and returns one result word per sample. A sample
// passes through the input register and then the result register: all
// filtering and gain control for a sample is done in the single pass
// between them, and the result register is free to take the next sample
// whenever its word is taken, so the stream runs at one word per cycle. While
// the result waits, one further sample is held in the input register. There is
// no clearing pass after reset. Configuration writes take effect on the next
// clock edge; dc_low and dc_high are stored pre-scaled by the window length,
// so the window mean is compared without a divider.
module ppg_led_agc_fir_front_end
    import ppgfe_pkg::*;
#(
    parameter int AGC_WINDOW  = 25,
    parameter int SAMPLE_BITS = 18
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [REG_W-1:0]              cfg_wdata,
    // Sample input: raw_ir, raw_red (lowest bits first)
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // Result output: filt_ir, filt_red, finger_on, led_drive, drive_changed
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [((2*SAMPLE_BITS+DRV_W+2+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_FIELDS_W = 2*SAMPLE_BITS + DRV_W + 2;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int HIST_D       = 4;
    localparam int CNT_W        = $clog2(AGC_WINDOW + 1);
    localparam int SUM_W        = SAMPLE_BITS + CNT_W;
    localparam int TH_W         = REG_W + 1 + CNT_W;
    localparam int CMP_W        = (SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W;
    localparam int CMPS_W       = (SUM_W > TH_W) ? SUM_W : TH_W;
    localparam int ACC_W        = SAMPLE_BITS + 4;
    localparam int SH           = ACC_W + 3;
    localparam int PROD_W       = 2 * ACC_W;
    localparam logic [63:0]      RECIP_FULL = (64'd1 << SH) / 64'd10;
    localparam logic [ACC_W-1:0] RECIP      = RECIP_FULL[ACC_W-1:0];
    localparam logic [ACC_W-1:0] TEN        = ACC_W'(10);
    localparam logic [CNT_W-1:0] LAST_CNT   = CNT_W'(AGC_WINDOW - 1);

    // Floor of the 1-2-4-2-1 weighted sum over ten. The reciprocal estimate is
    // at most one short, so a single remainder check completes the quotient.
    function automatic logic [SAMPLE_BITS-1:0] fir5(
        input logic [SAMPLE_BITS-1:0] x0,
        input logic [SAMPLE_BITS-1:0] x1,
        input logic [SAMPLE_BITS-1:0] x2,
        input logic [SAMPLE_BITS-1:0] x3,
        input logic [SAMPLE_BITS-1:0] x4
    );
        logic [ACC_W-1:0]    acc;
        logic [PROD_W-1:0]   prod;
        logic [ACC_W-4:0]    q_est;
        logic [ACC_W-1:0]    rem;
        logic [ACC_W-1:0]    quot;
        acc   = ACC_W'(x0) + (ACC_W'(x1) << 1) + (ACC_W'(x2) << 2)
              + (ACC_W'(x3) << 1) + ACC_W'(x4);
        prod  = PROD_W'(acc) * PROD_W'(RECIP);
        q_est = prod[PROD_W-1:SH];
        rem   = acc - ACC_W'(q_est) * TEN;
        quot  = ACC_W'(q_est) + ACC_W'(rem >= TEN);
        return quot[SAMPLE_BITS-1:0];
    endfunction

    // Configuration registers
    logic [REG_W-1:0] finger_threshold_reg;
    logic [TH_W-1:0]  low_scaled_reg;    // dc_low * window
    logic [TH_W-1:0]  high_scaled_reg;   // (dc_high + 1) * window
    logic [DRV_W-1:0] drive_step_reg;
    logic [DRV_W-1:0] drive_min_reg;
    logic [DRV_W-1:0] drive_max_reg;
    logic [DRV_W-1:0] drive_initial_reg;

    // Pipeline and state registers
    logic                   in_valid_reg,  in_valid_next;
    logic [SAMPLE_BITS-1:0] in_ir_reg;
    logic [SAMPLE_BITS-1:0] in_red_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_data_reg;
    logic [SAMPLE_BITS-1:0] ir_hist_reg  [HIST_D];
    logic [SAMPLE_BITS-1:0] red_hist_reg [HIST_D];
    logic [SUM_W-1:0]       dc_sum_reg,    dc_sum_next;
    logic [CNT_W-1:0]       dc_cnt_reg,    dc_cnt_next;
    logic [DRV_W-1:0]       drive_reg,     drive_next;
    logic                   prev_finger_reg;

    logic                   out_free;
    logic                   advance;
    logic                   s_accept;
    logic                   finger;
    logic                   changed;
    logic [SUM_W-1:0]       win_sum;
    logic [DRV_W:0]         drive_up;
    logic [SAMPLE_BITS-1:0] filt_ir;
    logic [SAMPLE_BITS-1:0] filt_red;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (out_free ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Gain control and smoothing for the sample in the input register.
    always_comb begin
        finger      = CMP_W'(in_ir_reg) > CMP_W'(finger_threshold_reg);
        win_sum     = dc_sum_reg + SUM_W'(in_ir_reg);
        drive_up    = {1'b0, drive_reg} + {1'b0, drive_step_reg};
        drive_next  = drive_reg;
        dc_sum_next = '0;
        dc_cnt_next = '0;
        if (prev_finger_reg && !finger) begin
            drive_next = drive_initial_reg;
        end
        if (finger) begin
            if (dc_cnt_reg == LAST_CNT) begin
                if (CMPS_W'(win_sum) < CMPS_W'(low_scaled_reg) &&
                    drive_reg < drive_max_reg) begin
                    drive_next = (drive_up < {1'b0, drive_max_reg}) ?
                                 drive_up[DRV_W-1:0] : drive_max_reg;
                end else if (CMPS_W'(win_sum) >= CMPS_W'(high_scaled_reg) &&
                             drive_reg > drive_min_reg) begin
                    // drive - step > min is tested as drive > min + step.
                    drive_next = ({1'b0, drive_reg} >
                                  {1'b0, drive_min_reg} + {1'b0, drive_step_reg}) ?
                                 drive_reg - drive_step_reg : drive_min_reg;
                end
            end else begin
                dc_sum_next = win_sum;
                dc_cnt_next = dc_cnt_reg + CNT_W'(1);
            end
        end
        changed  = drive_next != drive_reg;
        filt_ir  = fir5(in_ir_reg, ir_hist_reg[0], ir_hist_reg[1],
                        ir_hist_reg[2], ir_hist_reg[3]);
        filt_red = fir5(in_red_reg, red_hist_reg[0], red_hist_reg[1],
                        red_hist_reg[2], red_hist_reg[3]);
    end

    // Configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finger_threshold_reg <= FINGER_THRESHOLD_RST;
            low_scaled_reg       <= TH_W'(DC_LOW_RST) * TH_W'(AGC_WINDOW);
            high_scaled_reg      <= (TH_W'(DC_HIGH_RST) + TH_W'(1)) * TH_W'(AGC_WINDOW);
            drive_step_reg       <= DRIVE_STEP_RST;
            drive_min_reg        <= DRIVE_MIN_RST;
            drive_max_reg        <= DRIVE_MAX_RST;
            drive_initial_reg    <= DRIVE_INITIAL_RST;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            dc_sum_reg           <= '0;
            dc_cnt_reg           <= '0;
            drive_reg            <= DRIVE_INITIAL_RST;
            prev_finger_reg      <= 1'b0;
            for (int i = 0; i < HIST_D; i++) begin
                ir_hist_reg[i]  <= '0;
                red_hist_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_FINGER_THRESHOLD: finger_threshold_reg <= cfg_wdata;
                    CFG_DC_LOW: begin
                        low_scaled_reg <= TH_W'(cfg_wdata) * TH_W'(AGC_WINDOW);
                    end
                    CFG_DC_HIGH: begin
                        high_scaled_reg <= (TH_W'(cfg_wdata) + TH_W'(1)) *
                                           TH_W'(AGC_WINDOW);
                    end
                    CFG_DRIVE_STEP:    drive_step_reg    <= cfg_wdata[DRV_W-1:0];
                    CFG_DRIVE_MIN:     drive_min_reg     <= cfg_wdata[DRV_W-1:0];
                    CFG_DRIVE_MAX:     drive_max_reg     <= cfg_wdata[DRV_W-1:0];
                    CFG_DRIVE_INITIAL: drive_initial_reg <= cfg_wdata[DRV_W-1:0];
                    default: ;
                endcase
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                dc_sum_reg      <= dc_sum_next;
                dc_cnt_reg      <= dc_cnt_next;
                drive_reg       <= drive_next;
                prev_finger_reg <= finger;
                ir_hist_reg[0]  <= in_ir_reg;
                red_hist_reg[0] <= in_red_reg;
                for (int i = 1; i < HIST_D; i++) begin
                    ir_hist_reg[i]  <= ir_hist_reg[i-1];
                    red_hist_reg[i] <= red_hist_reg[i-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_ir_reg  <= s_tdata[SAMPLE_BITS-1:0];
            in_red_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (advance) begin
            out_data_reg <= OUT_W'({changed, drive_next, finger, filt_red, filt_ir});
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ppgfe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPG front end checker
// Port-level checks of the result stream, bound to the front end top level.
// ----------------------------------------------------------------------------
module ppgfe_checker
    import ppgfe_pkg::*;
#(
    parameter int SAMPLE_BITS = 18
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [((2*SAMPLE_BITS+DRV_W+2+7)/8)*8-1:0] m_tdata
);

    localparam int DRV_LSB = 2*SAMPLE_BITS + 1;
    localparam int CHG_BIT = DRV_LSB + DRV_W;

    logic [DRV_W-1:0] last_drive_reg;
    logic [1:0]       inflight_reg;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_drive_reg <= DRIVE_INITIAL_RST;
            inflight_reg   <= '0;
        end else begin
            if (out_acc) begin
                last_drive_reg <= m_tdata[CHG_BIT-1:DRV_LSB];
            end
            inflight_reg <= inflight_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    // A stalled result word must hold.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The change flag agrees with the drive carried by the previous word.
    a_drive_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> m_tdata[CHG_BIT] == (m_tdata[CHG_BIT-1:DRV_LSB] != last_drive_reg))
        else $error("drive_changed does not match led_drive history");

    // At most two samples are held between the input and the output.
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 2'd2)
        else $error("more samples in flight than the pipeline holds");

    // No result word is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind ppg_led_agc_fir_front_end ppgfe_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
